### hdl/srl_pkg.sv
`timescale 1ns / 1ps
package srl_pkg;
   localparam int ROW_WIDTH = 640;
   localparam int MAX_DEPTH = 7;
   localparam int COL_W = 10;
   localparam int DEPTH_W = 3;
   localparam int SEP_W = 8;
   localparam int H_W = $clog2(MAX_DEPTH + 1);
   localparam int STEP_W = $clog2(ROW_WIDTH + 1);
   localparam int LINK_W = COL_W + 1;
   localparam int SW = COL_W + 3;
   localparam int ADDR_W = 3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;
   localparam logic REG_SEP = 1'b0;
   localparam logic [SEP_W-1:0] SEP_RESET = SEP_W'(64);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(ROW_WIDTH - 1);

   typedef struct packed {
      logic [COL_W-1:0] dep_ra;
      logic             src_we;
      logic [COL_W-1:0] src_wa;
      logic [COL_W-1:0] src_wd;
   } pass_mem_type;
endpackage

### hdl/srl_ram.sv
`timescale 1ns / 1ps
module srl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 640,
   parameter int AW = 10
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    wa,
   input  logic [WIDTH-1:0] wd,
   input  logic [AW-1:0]    ra,
   output logic [WIDTH-1:0] rd
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_ff <= mem[ra];
   end

   assign rd = rd_ff;
endmodule

### hdl/srl_pass.sv
`timescale 1ns / 1ps
module srl_pass
   import srl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SEP_W-1:0]   sep,
   input  logic [DEPTH_W-1:0] dep_rd,
   output pass_mem_type       mem,
   output logic               busy
);
   typedef enum logic [3:0] {
      P_IDLE, P_INIT, P_BRD, P_BEV, P_RRD, P_RWR, P_LRD, P_LWR,
      P_KRD, P_KEV, P_TRD, P_TEV
   } state_type;

   state_type state_ff, state_in;
   logic [COL_W-1:0] x_ff, x_in, lx_ff, lx_in, rx_ff, rx_in, t_ff, t_in;
   logic [H_W-1:0] h_ff, h_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic [SEP_W-1:0] sep_ff, sep_in;

   logic r_we, l_we;
   logic [COL_W-1:0] r_wa, l_wa, r_ra, l_ra;
   logic [LINK_W-1:0] r_wd, l_wd, r_rd, l_rd;

   logic [COL_W:0] sum;
   logic [SW-1:0] lx_s, rx_s;
   logic in_row;

   srl_ram #(.WIDTH(LINK_W), .DEPTH(ROW_WIDTH), .AW(COL_W)) u_right (
      .clock(clock), .we(r_we), .wa(r_wa), .wd(r_wd), .ra(r_ra), .rd(r_rd)
   );
   srl_ram #(.WIDTH(LINK_W), .DEPTH(ROW_WIDTH), .AW(COL_W)) u_left (
      .clock(clock), .we(l_we), .wa(l_wa), .wd(l_wd), .ra(l_ra), .rd(l_rd)
   );

   assign sum = {1'b0, x_ff} + (COL_W+1)'(sep_ff);
   assign lx_s = SW'(x_ff) - SW'(sep_ff[SEP_W-1:1]) + SW'(h_ff);
   assign rx_s = SW'(x_ff) + SW'(sep_ff[SEP_W-1:1]) - SW'(h_ff);
   assign in_row = !lx_s[SW-1] && (lx_s <= SW'(ROW_WIDTH - 1)) &&
                   !rx_s[SW-1] && (rx_s <= SW'(ROW_WIDTH - 1)) &&
                   (SW'(dep_rd) == SW'(h_ff));
   assign busy = (state_ff != P_IDLE);

   always_comb begin
      state_in = state_ff;
      x_in = x_ff;
      lx_in = lx_ff;
      rx_in = rx_ff;
      t_in = t_ff;
      h_in = h_ff;
      steps_in = steps_ff;
      sep_in = sep_ff;
      r_we = 1'b0;
      l_we = 1'b0;
      r_wa = x_ff;
      l_wa = x_ff;
      r_wd = '0;
      l_wd = '0;
      r_ra = x_ff;
      l_ra = x_ff;
      mem.dep_ra = x_ff;
      mem.src_we = 1'b0;
      mem.src_wa = x_ff;
      mem.src_wd = x_ff;
      unique case (state_ff)
         P_IDLE: begin
            if (start) begin
               sep_in = sep;
               x_in = '0;
               state_in = P_INIT;
            end
         end
         P_INIT: begin
            r_we = 1'b1;
            r_wd = {(sum <= (COL_W+1)'(ROW_WIDTH - 1)), sum[COL_W-1:0]};
            l_we = 1'b1;
            l_wd = {(x_ff >= COL_W'(sep_ff)), x_ff - COL_W'(sep_ff)};
            mem.src_we = 1'b1;
            if (x_ff == LAST_COL) begin
               x_in = '0;
               h_in = H_W'(1);
               state_in = P_BRD;
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         P_BRD: state_in = P_BEV;
         P_BEV, P_LWR: begin
            if (state_ff == P_LWR) begin
               if (l_rd[LINK_W-1]) begin
                  r_we = 1'b1;
                  r_wa = l_rd[COL_W-1:0];
                  r_wd = '0;
               end
               l_we = 1'b1;
               l_wa = rx_ff;
               l_wd = {1'b1, lx_ff};
            end
            if (state_ff == P_BEV && in_row) begin
               lx_in = lx_s[COL_W-1:0];
               rx_in = rx_s[COL_W-1:0];
               state_in = P_RRD;
            end else if (x_ff == LAST_COL) begin
               x_in = '0;
               if (h_ff == H_W'(MAX_DEPTH)) begin
                  state_in = P_KRD;
               end else begin
                  h_in = h_ff + 1'b1;
                  state_in = P_BRD;
               end
            end else begin
               x_in = x_ff + 1'b1;
               state_in = P_BRD;
            end
         end
         P_RRD: begin
            r_ra = lx_ff;
            state_in = P_RWR;
         end
         P_RWR: begin
            if (r_rd[LINK_W-1]) begin
               l_we = 1'b1;
               l_wa = r_rd[COL_W-1:0];
               l_wd = '0;
            end
            r_we = 1'b1;
            r_wa = lx_ff;
            r_wd = {1'b1, rx_ff};
            state_in = P_LRD;
         end
         P_LRD: begin
            l_ra = rx_ff;
            state_in = P_LWR;
         end
         P_KRD: state_in = P_KEV;
         P_KEV, P_TEV: begin
            if (state_ff == P_KEV && !l_rd[LINK_W-1]) begin
               t_in = x_ff;
               steps_in = '0;
               state_in = P_TRD;
            end else if (state_ff == P_TEV && r_rd[LINK_W-1] &&
                         steps_ff < STEP_W'(ROW_WIDTH)) begin
               t_in = r_rd[COL_W-1:0];
               mem.src_we = 1'b1;
               mem.src_wa = r_rd[COL_W-1:0];
               steps_in = steps_ff + 1'b1;
               state_in = P_TRD;
            end else if (x_ff == LAST_COL) begin
               state_in = P_IDLE;
            end else begin
               x_in = x_ff + 1'b1;
               state_in = P_KRD;
            end
         end
         P_TRD: begin
            r_ra = t_ff;
            state_in = P_TEV;
         end
         default: state_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
      end else begin
         state_ff <= state_in;
      end
      x_ff <= x_in;
      lx_ff <= lx_in;
      rx_ff <= rx_in;
      t_ff <= t_in;
      h_ff <= h_in;
      steps_ff <= steps_in;
      sep_ff <= sep_in;
   end
endmodule

### hdl/stereogram_row_linker.sv
`timescale 1ns / 1ps
// channel  dir  handshake                  payload
// req      in   req_valid / req_stall      req_kind req_column req_depth req_last
// rsp      out  rsp_valid / rsp_stall      rsp_out_column rsp_source_column
// csr      in   psel penable pwrite pready paddr pwdata prdata
// A load writes its depth; a taken read is held pending, then registered as the response.
// A load with last set starts the link pass: an init sweep over all 640 columns,
// then a bind sweep over every column for each depth level, then a sweep over
// every column that traces each chain from its start.
// Requests stall for the whole pass; the row memories have one read and one write port.
// Reset is synchronous; the separation returns to 64 and the memories keep contents.
// A stalled response holds; one more read parks behind it, then requests stall.
module stereogram_row_linker
   import srl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [COL_W-1:0]   req_column,
   input  logic [DEPTH_W-1:0] req_depth,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COL_W-1:0]   rsp_out_column,
   output logic [COL_W-1:0]   rsp_source_column,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   logic [SEP_W-1:0] sep_ff, sep_in;
   logic rd_pend_ff, rd_pend_in, rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0] rd_col_ff, rd_col_in, out_col_ff, out_col_in, src_ff, src_in;
   logic skid_valid_ff, skid_valid_in;
   logic [COL_W-1:0] skid_col_ff, skid_col_in, skid_src_ff, skid_src_in, new_src;
   logic accept, start, busy, dep_we, in_range;
   logic [DEPTH_W-1:0] dep_rd;
   logic [COL_W-1:0] src_rd;
   pass_mem_type pmem;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_SEP) ? 32'(sep_ff) : '0;
   assign sep_in = (psel && penable && pwrite && paddr[2] == REG_SEP) ?
                   pwdata[SEP_W-1:0] : sep_ff;

   assign req_stall = busy || rd_pend_ff || skid_valid_ff;
   assign accept = req_valid && !req_stall;
   assign in_range = (req_column <= LAST_COL);
   assign dep_we = accept && req_kind == KIND_LOAD && in_range;
   assign start = accept && req_kind == KIND_LOAD && req_last;

   srl_ram #(.WIDTH(DEPTH_W), .DEPTH(ROW_WIDTH), .AW(COL_W)) u_depth (
      .clock(clock), .we(dep_we), .wa(req_column), .wd(req_depth),
      .ra(pmem.dep_ra), .rd(dep_rd)
   );
   srl_ram #(.WIDTH(COL_W), .DEPTH(ROW_WIDTH), .AW(COL_W)) u_source (
      .clock(clock), .we(pmem.src_we), .wa(pmem.src_wa), .wd(pmem.src_wd),
      .ra(req_column), .rd(src_rd)
   );
   srl_pass u_pass (
      .clock(clock), .reset(reset), .start(start), .sep(sep_ff),
      .dep_rd(dep_rd), .mem(pmem), .busy(busy)
   );

   assign new_src = (rd_col_ff <= LAST_COL) ? src_rd : rd_col_ff;

   always_comb begin
      rd_pend_in = accept && req_kind == KIND_READ;
      rd_col_in = accept ? req_column : rd_col_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_col_in = out_col_ff;
      src_in = src_ff;
      skid_valid_in = skid_valid_ff;
      skid_col_in = skid_col_ff;
      skid_src_in = skid_src_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_in = 1'b1;
            out_col_in = skid_col_ff;
            src_in = skid_src_ff;
            skid_valid_in = 1'b0;
         end else if (rd_pend_ff) begin
            rsp_valid_in = 1'b1;
            out_col_in = rd_col_ff;
            src_in = new_src;
         end
      end else if (rd_pend_ff) begin
         skid_valid_in = 1'b1;
         skid_col_in = rd_col_ff;
         skid_src_in = new_src;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= SEP_RESET;
         rd_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         sep_ff <= sep_in;
         rd_pend_ff <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rd_col_ff <= rd_col_in;
      out_col_ff <= out_col_in;
      src_ff <= src_in;
      skid_col_ff <= skid_col_in;
      skid_src_ff <= skid_src_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_column = out_col_ff;
   assign rsp_source_column = src_ff;

   a_pend_to_rsp: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |=> rsp_valid_ff) else $error("read lost");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !accept) else $error("request taken during pass");
   a_read_pends: assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind == KIND_READ) |=> (rd_pend_ff && !busy))
      else $error("read not pending");
   a_skid_alone: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !rd_pend_ff) else $error("parked read overrun");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=>
      (rsp_valid_ff && $stable(out_col_ff) && $stable(src_ff)))
      else $error("stalled response changed");
endmodule
